@@ rtl/assert_macros.svh @@
// assertion macros for the rtl file that checks itself
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every rising clock edge outside reset
`define SHT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define SHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define SHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sht_pkg.sv @@
// types and constants of the syslog header tokenizer
// no dependencies
package sht_pkg;

    // character codes
    localparam logic [7:0] CH_LT       = 8'h3C;
    localparam logic [7:0] CH_GT       = 8'h3E;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBR      = 8'h5B;
    localparam logic [7:0] CH_RBR      = 8'h5D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CTRL_LIMIT  = 8'd32;

    localparam logic [9:0] CODE_MAX    = 10'd1023;
    localparam int unsigned CODE_W     = 10;
    localparam int unsigned PROD_W     = 14;

    // configuration register map
    localparam logic       REG_SUBST   = 1'b0;
    localparam logic [7:0] SUBST_RESET = 8'd63;

    // queue between front and back
    localparam int unsigned QDEPTH     = 2;
    localparam int unsigned QAW        = $clog2(QDEPTH);
    localparam int unsigned QCW        = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        PH_LT      = 4'd0,
        PH_CODE    = 4'd1,
        PH_DATE1   = 4'd2,
        PH_DATE2   = 4'd3,
        PH_PROG    = 4'd4,
        PH_PID     = 4'd5,
        PH_PIDTAIL = 4'd6,
        PH_GAP     = 4'd7,
        PH_MSG     = 4'd8,
        PH_FAIL    = 4'd9,
        PH_KMSG    = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        CL_HEADER = 3'd0,
        CL_DATE   = 3'd1,
        CL_PROG   = 3'd2,
        CL_PID    = 3'd3,
        CL_SEP    = 3'd4,
        CL_MSG    = 3'd5
    } class_t;

    typedef struct packed {
        logic       is_lt;
        logic       is_gt;
        logic       is_colon;
        logic       is_lbr;
        logic       is_rbr;
        logic       is_ws;
        logic       is_digit;
        logic [3:0] digit;
    } flags_t;

    typedef struct packed {
        logic [7:0] clean_byte;
        logic       eol;
        logic       kern;
        flags_t     flags;
    } tok_t;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           full;
        logic           empty;
    } q_stat_t;

endpackage

@@ rtl/sht_in_if.sv @@
// input channel of the tokenizer: one raw byte per item
// no dependencies
interface sht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_line;
    logic       from_kernel;

    modport source (output valid, output data_byte, output end_of_line,
                    output from_kernel, input ready);
    modport sink   (input valid, input data_byte, input end_of_line,
                    input from_kernel, output ready);
endinterface

@@ rtl/sht_out_if.sv @@
// output channel of the tokenizer: one tagged byte per item
// no dependencies
interface sht_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] clean_byte;
    logic [2:0] byte_class;
    logic       line_done;
    logic       line_ok;
    logic [6:0] facility;
    logic [2:0] priority_res;

    modport source (output valid, output clean_byte, output byte_class,
                    output line_done, output line_ok, output facility,
                    output priority_res, input ready);
    modport sink   (input valid, input clean_byte, input byte_class,
                    input line_done, input line_ok, input facility,
                    input priority_res, output ready);
endinterface

@@ rtl/syslog_header_tokenizer_unit.sv @@
// an accepted byte waits in the queue; its result is registered in the back stage when it is popped
// throughput: one byte per cycle while the output is taken, set by the phase update in the back stage
// a two-entry queue parts front and back, so each side stalls on its own
// reset (rst_n, async, active low): line state to expect '<', queue empty,
// no result pending, substitute character back to 63
`include "assert_macros.svh"

module syslog_header_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    sht_in_if.sink      in_ch,
    sht_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sht_pkg::*;

    // configuration: one register, word index taken from paddr[2]
    logic [7:0] subst_reg;
    logic       cfg_wr;

    // front to queue
    logic       push;
    tok_t       push_tok;

    // queue to back
    logic       pop;
    tok_t       pop_tok;
    q_stat_t    q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // read back the substitute character, zero beyond the register list
    assign prdata = (paddr[2] == REG_SUBST) ? {24'd0, subst_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            subst_reg <= SUBST_RESET;
        else if (cfg_wr && (paddr[2] == REG_SUBST))
            subst_reg <= pwdata[7:0];
    end

    // front: substitution and byte classification, takes an item whenever
    // the queue has room
    sht_front u_front (
        .in_ch      (in_ch),
        .subst_char (subst_reg),
        .q_full     (q_stat.full),
        .push       (push),
        .tok        (push_tok)
    );

    // queue: holds classified bytes while the back stage is stalled
    sht_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .stat     (q_stat)
    );

    // back: phase machine and result register, pops whenever the result
    // register is free or being taken
    sht_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_stat.empty),
        .tok     (pop_tok),
        .pop     (pop),
        .out_ch  (out_ch)
    );

    // checks
    `SHT_ASSERT_ALWAYS(a_q_bound, q_stat.count <= QCW'(QDEPTH), "queue count past depth")
    `SHT_ASSERT_IMPL(a_no_push_full, push, !q_stat.full, "push into a full queue")
    `SHT_ASSERT_IMPL(a_ok_needs_done, out_ch.valid && out_ch.line_ok,
                     out_ch.line_done, "line_ok without line_done")
    `SHT_ASSERT_IMPL(a_code_zero, out_ch.valid && !out_ch.line_ok,
                     out_ch.facility == 7'd0 && out_ch.priority_res == 3'd0,
                     "code fields set on a line that is not ok")
    `SHT_ASSERT_NEXT(a_pop_gives_item, pop, out_ch.valid, "popped item did not reach the output")

endmodule

@@ rtl/sht_front.sv @@
// front stage: accepts bytes, substitutes control characters, classifies
// depends on sht_pkg and sht_in_if
module sht_front (
    sht_in_if.sink          in_ch,
    input  logic [7:0]      subst_char,
    input  logic            q_full,
    output logic            push,
    output sht_pkg::tok_t   tok
);
    import sht_pkg::*;

    logic [7:0] b;

    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    assign b = (in_ch.data_byte < CTRL_LIMIT) ? subst_char : in_ch.data_byte;

    always_comb
    begin
        tok.clean_byte     = b;
        tok.eol            = in_ch.end_of_line;
        tok.kern           = in_ch.from_kernel;
        tok.flags.is_lt    = (b == CH_LT);
        tok.flags.is_gt    = (b == CH_GT);
        tok.flags.is_colon = (b == CH_COLON);
        tok.flags.is_lbr   = (b == CH_LBR);
        tok.flags.is_rbr   = (b == CH_RBR);
        tok.flags.is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        tok.flags.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        // '0'..'9' sit at 0x30..0x39, so the low nibble is the value
        tok.flags.digit    = b[3:0];
    end
endmodule

@@ rtl/sht_queue.sv @@
// short queue of classified bytes between front and back
// depends on sht_pkg
module sht_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sht_pkg::tok_t     push_tok,
    input  logic              pop,
    output sht_pkg::tok_t     pop_tok,
    output sht_pkg::q_stat_t  stat
);
    import sht_pkg::*;

    tok_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_tok    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

@@ rtl/sht_back.sv @@
// back stage: line phase machine, code accumulation and result register
// depends on sht_pkg and sht_out_if
module sht_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  sht_pkg::tok_t  tok,
    output logic           pop,
    sht_out_if.source      out_ch
);
    import sht_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                digits_done_reg, digits_done_next;
    logic                failed_reg, failed_next;

    logic                out_valid_reg;
    logic [7:0]          byte_reg;
    class_t              class_reg, class_next;
    logic                done_reg;
    logic                ok_reg, ok_next;
    logic [6:0]          fac_reg, fac_next;
    logic [2:0]          pri_reg, pri_next;

    logic [PROD_W-1:0]   code_x10;

    assign pop = !q_empty && (!out_valid_reg || out_ch.ready);

    // code * 10 + digit, as shifts
    assign code_x10 = {1'b0, code_reg, 3'b000} + {3'b000, code_reg, 1'b0}
                      + {{(PROD_W-4){1'b0}}, tok.flags.digit};

    always_comb
    begin
        phase_next       = phase_reg;
        code_next        = code_reg;
        digits_done_next = digits_done_reg;
        failed_next      = failed_reg;
        class_next       = CL_HEADER;
        ok_next          = 1'b0;
        fac_next         = '0;
        pri_next         = '0;

        unique case (phase_reg)
            PH_LT:
            begin
                if (tok.flags.is_lt)
                    phase_next = PH_CODE;
                else
                begin
                    phase_next  = PH_FAIL;
                    failed_next = 1'b1;
                end
            end
            PH_CODE:
            begin
                priority if (tok.flags.is_gt)
                begin
                    if (code_reg == '0)
                    begin
                        phase_next  = PH_FAIL;
                        failed_next = 1'b1;
                    end
                    else
                        phase_next = tok.kern ? PH_KMSG : PH_DATE1;
                end
                else if (!digits_done_reg && tok.flags.is_digit)
                    code_next = (code_x10 > PROD_W'(CODE_MAX)) ? CODE_MAX
                                                               : code_x10[CODE_W-1:0];
                else
                    digits_done_next = 1'b1;
            end
            PH_DATE1:
            begin
                class_next = CL_DATE;
                if (tok.flags.is_colon)
                    phase_next = PH_DATE2;
            end
            PH_DATE2:
            begin
                if (tok.flags.is_ws)
                begin
                    class_next = CL_SEP;
                    phase_next = PH_PROG;
                end
                else
                    class_next = CL_DATE;
            end
            PH_PROG:
            begin
                priority if (tok.flags.is_lbr)
                begin
                    class_next = CL_SEP;
                    phase_next = PH_PID;
                end
                else if (tok.flags.is_colon)
                begin
                    class_next = CL_SEP;
                    phase_next = PH_GAP;
                end
                else
                    class_next = CL_PROG;
            end
            PH_PID:
            begin
                if (tok.flags.is_rbr)
                begin
                    class_next = CL_SEP;
                    phase_next = PH_PIDTAIL;
                end
                else
                    class_next = CL_PID;
            end
            PH_PIDTAIL:
            begin
                class_next = CL_SEP;
                if (tok.flags.is_colon)
                    phase_next = PH_GAP;
            end
            PH_GAP:
            begin
                if (tok.flags.is_ws)
                    class_next = CL_SEP;
                else
                begin
                    class_next = CL_MSG;
                    phase_next = PH_MSG;
                end
            end
            PH_MSG, PH_KMSG:
                class_next = CL_MSG;
            PH_FAIL:
                class_next = CL_HEADER;
            default:
            begin
                phase_next  = PH_FAIL;
                failed_next = 1'b1;
            end
        endcase

        if (tok.eol)
        begin
            if (!failed_next && (phase_next == PH_GAP || phase_next == PH_MSG
                                 || phase_next == PH_KMSG))
            begin
                ok_next  = 1'b1;
                fac_next = code_next[9:3];
                pri_next = code_next[2:0];
            end
            phase_next       = PH_LT;
            code_next        = '0;
            digits_done_next = 1'b0;
            failed_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LT;
            code_reg        <= '0;
            digits_done_reg <= 1'b0;
            failed_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                code_reg        <= code_next;
                digits_done_reg <= digits_done_next;
                failed_reg      <= failed_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg  <= tok.clean_byte;
            class_reg <= class_next;
            done_reg  <= tok.eol;
            ok_reg    <= ok_next;
            fac_reg   <= fac_next;
            pri_reg   <= pri_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.clean_byte   = byte_reg;
    assign out_ch.byte_class   = class_reg;
    assign out_ch.line_done    = done_reg;
    assign out_ch.line_ok      = ok_reg;
    assign out_ch.facility     = fac_reg;
    assign out_ch.priority_res = pri_reg;
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the syslog header tokenizer: raw log lines in, tagged bytes out
// depends on sht_pkg, sht_in_if, sht_out_if and syslog_header_tokenizer_unit
module tb;
    import sht_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int TAIL_CYCLES     = 5;
    localparam logic [2:0] SUBST_ADDR = {REG_SUBST, 2'b00};

    // one tagged byte as the block should report it
    typedef struct packed {
        logic [7:0] clean;
        class_t     cls;
        logic       done;
        logic       ok;
        logic [6:0] fac;
        logic [2:0] pri;
    } token_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sht_in_if  in_if ();
    sht_out_if out_if ();

    syslog_header_tokenizer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bench's own copy of the line state and the substitute register
    phase_t      line_phase;
    int unsigned line_code;
    bit          past_digits;
    bit          line_failed;
    logic [7:0]  subst_byte;

    token_out_t  tokens_due[$];     // predicted items, oldest first
    int          errors;
    int          items_sent;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_req;          // long hold-off asked of the receiver
    int          hold_left;

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // space, or tab up to carriage return
    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic void restart_line();
        line_phase  = PH_LT;
        line_code   = 0;
        past_digits = 1'b0;
        line_failed = 1'b0;
    endfunction

    // advances the line state by one raw byte and returns the tagged item
    function automatic token_out_t tokenize_byte(input logic [7:0] raw, input logic eol,
                                                 input logic kern);
        logic [7:0]  b;
        int unsigned v;
        token_out_t  r;
        // control bytes are swapped before any test looks at them
        b = (raw < CTRL_LIMIT) ? subst_byte : raw;
        r = '0;
        r.clean = b;
        r.cls   = CL_HEADER;
        case (line_phase)
            PH_LT:
                if (b == CH_LT)
                    line_phase = PH_CODE;
                else
                begin
                    line_phase  = PH_FAIL;
                    line_failed = 1'b1;
                end
            PH_CODE:
                if (b == CH_GT)
                begin
                    // a zero code, or none at all, spoils the line
                    if (line_code == 0)
                    begin
                        line_phase  = PH_FAIL;
                        line_failed = 1'b1;
                    end
                    else
                        line_phase = kern ? PH_KMSG : PH_DATE1;
                end
                else if (!past_digits && b >= CH_ZERO && b <= CH_NINE)
                begin
                    v = line_code * 10 + (b - CH_ZERO);
                    line_code = (v > CODE_MAX) ? CODE_MAX : v;
                end
                else
                    past_digits = 1'b1;
            PH_DATE1:
            begin
                r.cls = CL_DATE;
                if (b == CH_COLON)
                    line_phase = PH_DATE2;
            end
            PH_DATE2:
                if (is_blank(b))
                begin
                    r.cls      = CL_SEP;
                    line_phase = PH_PROG;
                end
                else
                    r.cls = CL_DATE;
            PH_PROG:
                if (b == CH_LBR)
                begin
                    r.cls      = CL_SEP;
                    line_phase = PH_PID;
                end
                else if (b == CH_COLON)
                begin
                    r.cls      = CL_SEP;
                    line_phase = PH_GAP;
                end
                else
                    r.cls = CL_PROG;
            PH_PID:
                if (b == CH_RBR)
                begin
                    r.cls      = CL_SEP;
                    line_phase = PH_PIDTAIL;
                end
                else
                    r.cls = CL_PID;
            PH_PIDTAIL:
            begin
                r.cls = CL_SEP;
                if (b == CH_COLON)
                    line_phase = PH_GAP;
            end
            PH_GAP:
                if (is_blank(b))
                    r.cls = CL_SEP;
                else
                begin
                    r.cls      = CL_MSG;
                    line_phase = PH_MSG;
                end
            PH_MSG, PH_KMSG:
                r.cls = CL_MSG;
            default:
            begin
                line_phase  = PH_FAIL;
                line_failed = 1'b1;
            end
        endcase
        // last byte reports the verdict and the code, then a new line begins
        if (eol)
        begin
            r.done = 1'b1;
            if (!line_failed && (line_phase == PH_GAP || line_phase == PH_MSG ||
                                 line_phase == PH_KMSG))
            begin
                r.ok  = 1'b1;
                r.fac = 7'(line_code >> 3);
                r.pri = 3'(line_code);
            end
            restart_line();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offers one byte from a falling edge and returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] raw, input logic eol, input logic kern);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= raw;
        in_if.end_of_line <= eol;
        in_if.from_kernel <= kern;
        do
            @(posedge clk);
        while (!in_if.ready);
        tokens_due.push_back(tokenize_byte(raw, eol, kern));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit closes, input logic kern);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], closes && (i == s.len() - 1), kern);
    endtask

    // sender stops offering and waits until every predicted item has come back
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // printable byte that is no header delimiter (no colon, square or angle bracket); it may be a digit
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 126));
        while (b == CH_COLON || b == CH_LBR || b == CH_RBR || b == CH_GT || b == CH_LT);
        return b;
    endfunction

    // mostly a plain space; sometimes a control byte that only counts as blank
    // when the substitute itself is blank
    function automatic logic [7:0] blank_byte();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
    endfunction

    // one line: mostly well formed with random content, some cut short, some pure noise
    task automatic send_random_line();
        logic [7:0]  line[$];
        int unsigned pick;
        int unsigned cut;
        logic        kern;
        pick = $urandom_range(99);
        kern = ($urandom_range(3) == 0);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 12)) line.push_back(8'($urandom_range(255)));
        end
        else
        begin
            line.push_back(CH_LT);
            // no digits now and then, so a missing code shows up
            repeat ($urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 4))
                line.push_back(CH_ZERO + 8'($urandom_range(9)));
            // skipped bytes, which may hold digits; those after a non-digit must not count
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3)) line.push_back(text_byte());
            line.push_back(CH_GT);
            if (!kern)
            begin
                repeat ($urandom_range(0, 3)) line.push_back(text_byte());
                line.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) line.push_back(text_byte());
                line.push_back(blank_byte());
                repeat ($urandom_range(0, 4)) line.push_back(text_byte());
                if ($urandom_range(1))
                begin
                    line.push_back(CH_LBR);
                    repeat ($urandom_range(0, 3)) line.push_back(text_byte());
                    line.push_back(CH_RBR);
                    repeat ($urandom_range(0, 1)) line.push_back(text_byte());
                end
                line.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) line.push_back(blank_byte());
            end
            repeat ($urandom_range(0, 5)) line.push_back(8'($urandom_range(255)));
            // broken lines are cut at a random length, which may lie past the header or keep the whole line
            if (pick < 25)
            begin
                cut = $urandom_range(1, line.size());
                while (line.size() > cut)
                    line.delete(line.size() - 1);
            end
        end
        foreach (line[i])
            send_byte(line[i], i == line.size() - 1, kern);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    // setup then access phase; ends with psel low again so accesses never overlap
    task automatic apb_access(input logic write, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= SUBST_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (write)
            subst_byte = wdata[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic check_subst();
        logic [31:0] got;
        apb_access(1'b0, 32'd0, got);
        if (got[7:0] !== subst_byte)
        begin
            $display("%0t: substitute read back, expected %0h, actual %0h",
                     $time, subst_byte, got[7:0]);
            errors++;
        end
    endtask

    // only written with the block drained
    task automatic write_subst(input logic [7:0] value);
        logic [31:0] unused;
        wait_for_results();
        apb_access(1'b1, {24'd0, value}, unused);
        check_subst();
    endtask

    // ------------------------------------------------------------------
    // receiver side and checking
    // ------------------------------------------------------------------

    // random stalls, or a long hold-off counted here when asked for
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_if.ready <= 1'b0;
        end
        else
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // every item taken from the block is held against the oldest prediction
    always @(posedge clk)
    begin : result_check
        token_out_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $display("%0t: item with nothing predicted, byte %0h class %0d",
                         $time, out_if.clean_byte, out_if.byte_class);
                errors++;
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("clean_byte",   want.clean, out_if.clean_byte);
                check_field("byte_class",   8'(want.cls), 8'(out_if.byte_class));
                check_field("line_done",    8'(want.done), 8'(out_if.line_done));
                check_field("line_ok",      8'(want.ok), 8'(out_if.line_ok));
                check_field("facility",     8'(want.fac), 8'(out_if.facility));
                check_field("priority_res", 8'(want.pri), 8'(out_if.priority_res));
            end
        end
    end

    // run ends if nothing moves on any port for too long
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // substitute register must come out of reset at its default
    task automatic test_reset_value();
        check_subst();
    endtask

    // hand-made lines: every byte class, a control byte, byte 255, a saturated
    // kernel code, a zero code and a line without its opening bracket
    task automatic test_directed_lines();
        send_text("<13>x: p[7]: \t", 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_text("<9999>z", 1'b1, 1'b1);
        send_text("<0>", 1'b1, 1'b0);
        send_text("A", 1'b1, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int spct, input int rpct);
        int stop_at;
        stop_at       = items_sent + count;
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        while (items_sent < stop_at)
            send_random_line();
    endtask

    // receiver holds off while bytes keep coming, so the queue fills and input stalls;
    // then the sender pauses until everything has drained
    task automatic test_stalled_output();
        int stop_at;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = HOLD_OFF_CYCLES;
        stop_at       = items_sent + 30;
        while (items_sent < stop_at)
            send_random_line();
        wait_for_results();
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.end_of_line = 1'b0;
        in_if.from_kernel = 1'b0;
        out_if.ready      = 1'b0;
        errors            = 0;
        items_sent        = 0;
        idle_cycles       = 0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_req          = 0;
        hold_left         = 0;
        subst_byte        = SUBST_RESET;
        restart_line();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_value();
        test_directed_lines();

        // sender sparse, receiver sparser, default substitute
        test_random_traffic(240, 31, 54);

        // blank substitute turns control bytes into separators
        write_subst(CH_SPACE);
        test_random_traffic(240, 54, 31);

        // no idling, substitute at both extremes
        write_subst(8'h00);
        test_random_traffic(110, 0, 0);
        write_subst(8'hFF);
        test_random_traffic(110, 0, 0);

        test_stalled_output();

        write_subst(8'($urandom_range(255)));
        test_random_traffic(40, 0, 0);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && tokens_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sht_pkg.sv
rtl/sht_in_if.sv
rtl/sht_out_if.sv
rtl/sht_front.sv
rtl/sht_queue.sv
rtl/sht_back.sv
rtl/syslog_header_tokenizer_unit.sv
tb/sv/tb.sv
